@@ rtl/size_class_slot_allocator_unit_assert.svh @@
// assertion macros for the slot allocator
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCSA_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("allocator check failed");

// next-cycle implication, sampled on clk, off during reset
`define SCSA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("allocator check failed");

`endif

@@ rtl/scsa_pkg.sv @@
// shared types and codes of the slot allocator
package scsa_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] CLS_SMALL   = 2'd0;
	localparam logic [1:0] CLS_MEDIUM  = 2'd1;
	localparam logic [1:0] CLS_LARGE   = 2'd2;
	localparam logic [1:0] CLS_FOREIGN = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
	localparam logic [2:0] ST_FOREIGN    = 3'd3;
	localparam logic [2:0] ST_EMPTY_PAGE = 3'd4;

	localparam logic CFG_SMALL_LIMIT  = 1'b0;
	localparam logic CFG_MEDIUM_LIMIT = 1'b1;

	localparam logic [15:0] SMALL_LIMIT_RESET  = 16'd24;
	localparam logic [15:0] MEDIUM_LIMIT_RESET = 16'd184;

	typedef struct packed {
		logic        op;
		logic [15:0] request_bytes;
		logic [1:0]  pool_class;
		logic [3:0]  page_index;
		logic [4:0]  slot_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  granted_class;
		logic [3:0]  granted_page;
		logic [4:0]  granted_slot;
		logic [15:0] large_in_use;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/size_class_slot_allocator_unit.sv @@
// Slot allocator with small and medium pooled classes and a large counter.
// Input channel in_valid/in_stall carries one request beat (allocate or
// free); output channel out_valid/out_stall returns exactly one result beat
// per request. Configuration writes on cfg_valid/cfg_ready set the small
// (index 0) and medium (index 1) byte limits; cfg_ready is always high.
// The user must see that writes are made only while the block is idle;
// the block itself does not enforce this. A request is captured, then the
// page scan and the stack memory read are registered in the lookup state,
// and then the result is committed into the output register. One request
// is in work at a time, and the next one is taken only after the commit;
// the page scan and the stack memory read-modify-write require this.
// While the output register holds a result that is stalled, the commit
// waits, and in_stall stays high until the result moves out.
// Reset clears the page tables and the large counter and sets the limits
// to 24 and 184; the stack memories need no clearing, since untouched
// entries read as identity.
module size_class_slot_allocator_unit #(
	parameter int SMALL_PAGES  = 16,
	parameter int SMALL_SLOTS  = 32,
	parameter int MEDIUM_PAGES = 16,
	parameter int MEDIUM_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scsa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output scsa_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [15:0]    small_limit_q;
	logic [15:0]    medium_limit_q;
	scsa_pkg::cmd_t cmd;
	scsa_pkg::sts_t sts;

	// limit registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_limit_q  <= scsa_pkg::SMALL_LIMIT_RESET;
			medium_limit_q <= scsa_pkg::MEDIUM_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				scsa_pkg::CFG_SMALL_LIMIT:  small_limit_q  <= cfg_data;
				scsa_pkg::CFG_MEDIUM_LIMIT: medium_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .sts(sts)
	);

	scsa_dp #(
		.SMALL_PAGES(SMALL_PAGES), .SMALL_SLOTS(SMALL_SLOTS),
		.MEDIUM_PAGES(MEDIUM_PAGES), .MEDIUM_SLOTS(MEDIUM_SLOTS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
		.small_limit(small_limit_q), .medium_limit(medium_limit_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

@@ rtl/scsa_pool.sv @@
// one pooled size class: page table, free-index stack memory and page scan
module scsa_pool #(
	parameter int PAGES = 16,
	parameter int SLOTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       lookup,
	input  logic       commit,
	input  logic       alloc,
	input  logic [3:0] free_page,
	input  logic [4:0] free_slot,
	output logic       hit,
	output logic       empty,
	output logic [3:0] grant_page,
	output logic [4:0] grant_slot
);

	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int UW = $clog2(SLOTS + 1);
	localparam int DEPTH = PAGES * SLOTS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// page table: live flag, fill level and peak fill since bring-up
	logic [PAGES-1:0] live_q;
	logic [UW-1:0]    used_q [PAGES];
	logic [UW-1:0]    peak_q [PAGES];
	logic [SW-1:0]    mem [DEPTH];
	logic [SW-1:0]    rdata_q;

	logic          scan_hit;
	logic [PW-1:0] scan_pg;
	logic          scan_new;
	logic [UW-1:0] scan_u;
	logic [UW-1:0] scan_pk;
	logic          f_inrange;
	logic [PW-1:0] f_pg;
	logic [UW-1:0] f_u;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [UW-1:0] u_next;

	logic          alloc_s2;
	logic          hit_s2;
	logic          empty_s2;
	logic [PW-1:0] pg_s2;
	logic [UW-1:0] u_s2;
	logic [UW-1:0] pk_s2;
	logic          ident_s2;
	logic [SW-1:0] slot_s2;

	// first page that is unused or not full, lowest index wins
	always_comb begin
		scan_hit = 1'b0;
		scan_pg = '0;
		for (int p = PAGES - 1; p >= 0; p--) begin
			if (!live_q[p] || (used_q[p] < UW'(SLOTS))) begin
				scan_hit = 1'b1;
				scan_pg = PW'(p);
			end
		end
	end

	assign scan_new = !live_q[scan_pg];
	assign scan_u   = scan_new ? '0 : used_q[scan_pg];
	assign scan_pk  = scan_new ? '0 : peak_q[scan_pg];

	// free handle lookup
	assign f_inrange = (int'(free_page) < PAGES) && (int'(free_slot) < SLOTS);
	assign f_pg      = PW'(free_page);
	assign f_u       = f_inrange ? used_q[f_pg] : '0;

	assign raddr  = AW'(int'(scan_pg) * SLOTS + int'(scan_u));
	assign waddr  = AW'(int'(pg_s2) * SLOTS + int'(u_s2) - 1);
	assign u_next = alloc_s2 ? (u_s2 + 1'b1) : (u_s2 - 1'b1);

	// lookup stage registers
	always_ff @(posedge clk) begin
		if (lookup) begin
			alloc_s2 <= alloc;
			hit_s2   <= alloc ? scan_hit : f_inrange;
			empty_s2 <= (f_u == '0);
			pg_s2    <= alloc ? scan_pg : f_pg;
			u_s2     <= alloc ? scan_u : f_u;
			pk_s2    <= scan_pk;
			ident_s2 <= (scan_u >= scan_pk);
			slot_s2  <= SW'(free_slot);
		end
	end

	// free-index stack memory, read on lookup, pushed on a free commit
	always_ff @(posedge clk) begin
		if (lookup) begin
			rdata_q <= mem[raddr];
		end
		if (commit && !alloc_s2) begin
			mem[waddr] <= slot_s2;
		end
	end

	// page table update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			for (int p = 0; p < PAGES; p++) begin
				used_q[p] <= '0;
				peak_q[p] <= '0;
			end
		end else if (commit) begin
			used_q[pg_s2] <= u_next;
			if (alloc_s2) begin
				live_q[pg_s2] <= 1'b1;
				peak_q[pg_s2] <= (u_next > pk_s2) ? u_next : pk_s2;
			end
		end
	end

	// positions never pushed since bring-up are given as identity
	assign hit        = hit_s2;
	assign empty      = empty_s2;
	assign grant_page = 4'(pg_s2);
	assign grant_slot = ident_s2 ? 5'(u_s2) : 5'(rdata_q);

endmodule

@@ rtl/scsa_dp.sv @@
// datapath: request decode, both pools, large counter and result register
module scsa_dp #(
	parameter int SMALL_PAGES  = 16,
	parameter int SMALL_SLOTS  = 32,
	parameter int MEDIUM_PAGES = 16,
	parameter int MEDIUM_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scsa_pkg::cmd_t      cmd,
	output scsa_pkg::sts_t      sts,
	input  scsa_pkg::in_item_t  in_data,
	input  logic [15:0]         small_limit,
	input  logic [15:0]         medium_limit,
	output logic                out_valid,
	input  logic                out_stall,
	output scsa_pkg::out_item_t out_data
);

	scsa_pkg::in_item_t  req_q;
	logic [1:0]          acls_q;
	logic                bad_q;
	logic [15:0]         large_q;
	logic                out_valid_q;
	scsa_pkg::out_item_t out_q;
	scsa_pkg::out_item_t res;
	logic [15:0]         large_next;

	logic       sel_small;
	logic       sel_medium;
	logic       pool_alloc;
	logic       s_hit, s_empty, m_hit, m_empty;
	logic [3:0] s_page, m_page;
	logic [4:0] s_slot, m_slot;
	logic       s_commit, m_commit;

	// capture the request and pick its class
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
			bad_q <= (in_data.request_bytes == '0);
			if (in_data.request_bytes <= small_limit) begin
				acls_q <= scsa_pkg::CLS_SMALL;
			end else if (in_data.request_bytes <= medium_limit) begin
				acls_q <= scsa_pkg::CLS_MEDIUM;
			end else begin
				acls_q <= scsa_pkg::CLS_LARGE;
			end
		end
	end

	assign pool_alloc = (req_q.op == scsa_pkg::OP_ALLOC);
	assign sel_small  = pool_alloc ? (!bad_q && acls_q == scsa_pkg::CLS_SMALL)
	                               : (req_q.pool_class == scsa_pkg::CLS_SMALL);
	assign sel_medium = pool_alloc ? (!bad_q && acls_q == scsa_pkg::CLS_MEDIUM)
	                               : (req_q.pool_class == scsa_pkg::CLS_MEDIUM);

	// a pool changes only on a successful take or give
	assign s_commit = cmd.commit && sel_small && s_hit && (pool_alloc || !s_empty);
	assign m_commit = cmd.commit && sel_medium && m_hit && (pool_alloc || !m_empty);

	scsa_pool #(.PAGES(SMALL_PAGES), .SLOTS(SMALL_SLOTS)) u_small (
		.clk(clk), .arst_n(arst_n), .lookup(cmd.lookup), .commit(s_commit),
		.alloc(pool_alloc), .free_page(req_q.page_index), .free_slot(req_q.slot_index),
		.hit(s_hit), .empty(s_empty), .grant_page(s_page), .grant_slot(s_slot)
	);

	scsa_pool #(.PAGES(MEDIUM_PAGES), .SLOTS(MEDIUM_SLOTS)) u_medium (
		.clk(clk), .arst_n(arst_n), .lookup(cmd.lookup), .commit(m_commit),
		.alloc(pool_alloc), .free_page(req_q.page_index), .free_slot(req_q.slot_index),
		.hit(m_hit), .empty(m_empty), .grant_page(m_page), .grant_slot(m_slot)
	);

	// result and large counter
	always_comb begin
		res = '0;
		large_next = large_q;
		if (pool_alloc) begin
			if (bad_q) begin
				res.status = scsa_pkg::ST_BAD_SIZE;
			end else if (acls_q == scsa_pkg::CLS_LARGE) begin
				res.granted_class = scsa_pkg::CLS_LARGE;
				if (large_q != 16'hFFFF) begin
					large_next = large_q + 16'd1;
				end
			end else if (acls_q == scsa_pkg::CLS_SMALL) begin
				if (s_hit) begin
					res.granted_class = scsa_pkg::CLS_SMALL;
					res.granted_page = s_page;
					res.granted_slot = s_slot;
				end else begin
					res.status = scsa_pkg::ST_EXHAUSTED;
				end
			end else begin
				if (m_hit) begin
					res.granted_class = scsa_pkg::CLS_MEDIUM;
					res.granted_page = m_page;
					res.granted_slot = m_slot;
				end else begin
					res.status = scsa_pkg::ST_EXHAUSTED;
				end
			end
		end else begin
			unique case (req_q.pool_class)
				scsa_pkg::CLS_FOREIGN: res.status = scsa_pkg::ST_FOREIGN;
				scsa_pkg::CLS_LARGE: begin
					if (large_q == '0) begin
						res.status = scsa_pkg::ST_EMPTY_PAGE;
					end else begin
						large_next = large_q - 16'd1;
					end
				end
				scsa_pkg::CLS_SMALL: begin
					if (!s_hit) res.status = scsa_pkg::ST_FOREIGN;
					else if (s_empty) res.status = scsa_pkg::ST_EMPTY_PAGE;
				end
				default: begin
					if (!m_hit) res.status = scsa_pkg::ST_FOREIGN;
					else if (m_empty) res.status = scsa_pkg::ST_EMPTY_PAGE;
				end
			endcase
		end
		res.large_in_use = large_next;
	end

	// output register and large counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_q <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			large_q <= large_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.out_busy = out_valid_q && out_stall;

endmodule

@@ rtl/scsa_ctrl.sv @@
// controller: sequences capture, lookup and commit of one request
`include "size_class_slot_allocator_unit_assert.svh"
module scsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output scsa_pkg::cmd_t cmd,
	input  scsa_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_COMMIT
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_LOOK;
				S_LOOK:   state_q <= S_COMMIT;
				S_COMMIT: if (!sts.out_busy) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// commands
	assign in_stall    = (state_q != S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.lookup  = (state_q == S_LOOK);
	assign cmd.commit  = (state_q == S_COMMIT) && !sts.out_busy;

	`SCSA_ASSERT_NOW(a_commit_free, cmd.commit, !sts.out_busy)
	`SCSA_ASSERT_NEXT(a_capture_look, cmd.capture, cmd.lookup && in_stall)
	`SCSA_ASSERT_NEXT(a_look_hold, cmd.lookup, in_stall && !cmd.capture)

endmodule
